/* hdl/mpk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpk_pkg
// Shared types and constants for the k-transaction max profit block.
// ----------------------------------------------------------------------------
package mpk_pkg;

  localparam int MAX_TRANS = 16;
  localparam int IDX_W     = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
  localparam int PRICE_W   = 32;
  localparam int PROFIT_W  = 48;
  localparam int LIMIT_W   = 5;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(1);
  localparam logic [PROFIT_W-1:0] PROFIT_MAX  = {PROFIT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CAND,
    ST_UPDATE,
    ST_OUT
  } mpk_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // capture input word
    logic calc_diff;  // form day difference, or clear rows on a first day
    logic calc_cand;  // form per-lane candidates
    logic update;     // commit new rows
    logic load_out;   // load result register
  } mpk_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic first_day;
  } mpk_status_t;

endpackage

/* hdl/mpk_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpk_ctrl
// Sequencer: steps one price word through diff, candidate and update
// phases and owns the input ready and output valid handshake.
// ----------------------------------------------------------------------------
module mpk_ctrl
  import mpk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  mpk_status_t status,
  output mpk_cmd_t    cmd
);

  mpk_state_t state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       out_free;

  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = status.first_day ? ST_OUT : ST_CAND;
      ST_CAND:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      ST_DIFF:   cmd.calc_diff = 1'b1;
      ST_CAND:   cmd.calc_cand = 1'b1;
      ST_UPDATE: cmd.update    = 1'b1;
      ST_OUT:    cmd.load_out  = out_free;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  assign out_tvalid = out_tvalid_r;

`ifndef NO_ASSERTIONS
  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten");

  a_accept_to_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DIFF))
    else $error("accepted word not processed");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(cmd.load_out))
    else $error("output valid without a loaded result");

  a_update_after_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> ($past(state_r) == ST_CAND))
    else $error("rows committed without candidates");
`endif

endmodule

/* hdl/mpk_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpk_datapath
// Profit rows, one cell per transaction count, updated in parallel from
// the previous row; limit register and result register.
// ----------------------------------------------------------------------------
module mpk_datapath
  import mpk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  mpk_cmd_t            cmd,
  output mpk_status_t         status,
  input  logic [PRICE_W-1:0]  in_price,
  input  logic                in_first_day,
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data,
  output logic [PROFIT_W-1:0] out_best_profit
);

  localparam int SUM_W  = PROFIT_W + 1;
  localparam int HOLD_W = PROFIT_W + 2;

  logic [LIMIT_W-1:0]  limit_r;
  logic [PRICE_W-1:0]  price_r;
  logic                first_r;
  logic [PRICE_W-1:0]  prev_r;
  logic signed [PRICE_W:0] diff_r, diff_nxt;
  logic [PRICE_W-1:0]  gain_r, gain_nxt;

  logic [PROFIT_W-1:0] sell_r [MAX_TRANS];
  logic [PROFIT_W-1:0] best_r [MAX_TRANS];
  logic [PROFIT_W-1:0] open_r [MAX_TRANS];
  logic [PROFIT_W-1:0] hold_r [MAX_TRANS];
  logic [PROFIT_W-1:0] open_nxt [MAX_TRANS];
  logic [PROFIT_W-1:0] hold_nxt [MAX_TRANS];
  logic [PROFIT_W-1:0] sell_nxt [MAX_TRANS];
  logic [PROFIT_W-1:0] best_nxt [MAX_TRANS];

  logic [PROFIT_W-1:0] result_r, result_nxt;
  logic [LIMIT_W-1:0]  k_eff;

  assign status.first_day = first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      price_r <= in_price;
      first_r <= in_first_day;
    end
    if (cmd.calc_diff) begin
      diff_r <= diff_nxt;
      gain_r <= gain_nxt;
    end
    if (cmd.load_out) begin
      result_r <= result_nxt;
    end
  end

  // day difference, widened by one bit so it keeps its sign
  always_comb begin
    diff_nxt = $signed({1'b0, price_r}) - $signed({1'b0, prev_r});
    gain_nxt = (diff_nxt > 0) ? diff_nxt[PRICE_W-1:0] : '0;
  end

  // per-lane candidates, saturated to the profit range
  always_comb begin
    logic [SUM_W-1:0]         osum;
    logic signed [HOLD_W-1:0] hsum;
    logic [PROFIT_W-1:0]      prior;
    for (int j = 0; j < MAX_TRANS; j++) begin
      prior = (j == 0) ? '0 : best_r[(j == 0) ? 0 : j - 1];
      osum  = {1'b0, prior} + SUM_W'(gain_r);
      open_nxt[j] = osum[PROFIT_W] ? PROFIT_MAX : osum[PROFIT_W-1:0];
      hsum  = $signed({2'b00, sell_r[j]})
            + $signed({{(HOLD_W-PRICE_W-1){diff_r[PRICE_W]}}, diff_r});
      if (hsum[HOLD_W-1]) begin
        hold_nxt[j] = '0;
      end else if (hsum[PROFIT_W]) begin
        hold_nxt[j] = PROFIT_MAX;
      end else begin
        hold_nxt[j] = hsum[PROFIT_W-1:0];
      end
    end
  end

  // three comparisons side by side, then selection
  always_comb begin
    logic o_gt_h, o_gt_b, h_gt_b;
    for (int j = 0; j < MAX_TRANS; j++) begin
      o_gt_h = open_r[j] > hold_r[j];
      o_gt_b = open_r[j] > best_r[j];
      h_gt_b = hold_r[j] > best_r[j];
      sell_nxt[j] = o_gt_h ? open_r[j] : hold_r[j];
      if (o_gt_h) begin
        best_nxt[j] = o_gt_b ? open_r[j] : best_r[j];
      end else begin
        best_nxt[j] = h_gt_b ? hold_r[j] : best_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_cand) begin
      for (int j = 0; j < MAX_TRANS; j++) begin
        open_r[j] <= open_nxt[j];
        hold_r[j] <= hold_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      for (int j = 0; j < MAX_TRANS; j++) begin
        sell_r[j] <= '0;
        best_r[j] <= '0;
      end
    end else if (cmd.calc_diff && first_r) begin
      prev_r <= price_r;
      for (int j = 0; j < MAX_TRANS; j++) begin
        sell_r[j] <= '0;
        best_r[j] <= '0;
      end
    end else if (cmd.update) begin
      prev_r <= price_r;
      for (int j = 0; j < MAX_TRANS; j++) begin
        sell_r[j] <= sell_nxt[j];
        best_r[j] <= best_nxt[j];
      end
    end
  end

  // limits above the row count read the top row
  always_comb begin
    k_eff = (limit_r > LIMIT_W'(MAX_TRANS)) ? LIMIT_W'(MAX_TRANS) : limit_r;
    if (k_eff == '0) begin
      result_nxt = '0;
    end else begin
      result_nxt = best_r[IDX_W'(k_eff - LIMIT_W'(1))];
    end
  end

  assign out_best_profit = result_r;

endmodule

/* hdl/max_profit_k_transactions.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_profit_k_transactions
// Best trading profit with at most k buy-sell transactions over a stream
// of daily prices, one result word per price word.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in_      slave      tvalid / tready    tdata: price; tuser: first_day
//  out_     master     tvalid / tready    tdata: best_profit
//  cfg_     slave      wr_en              wr_data: transaction_limit
//
//  A price word passes the diff, candidate, update and output phases of the
//  sequencer shared by all row cells, a first-day word only diff and output;
//  a new word is taken only once the sequencer is back in idle.
//  Reset (rst_n low, synchronous) clears the rows, the previous price and
//  sets the limit to 1.
//  A stalled result holds in the output register; the next word is taken
//  meanwhile and waits in its last phase until that register is free.
// ----------------------------------------------------------------------------
module max_profit_k_transactions
  import mpk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] price
  input  logic        in_tuser,   // [0] first_day
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [47:0] best_profit
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  mpk_cmd_t    cmd;
  mpk_status_t status;

  mpk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mpk_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_price        (in_tdata),
    .in_first_day    (in_tuser),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_best_profit (out_tdata)
  );

endmodule
